// File: design/ppu_pkg.sv
`timescale 1ns / 1ps

package ppu_pkg;

  // Channel and datapath widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned PixInW  = 32;
  localparam int unsigned PixOutW = 16;
  localparam int unsigned RecipW  = 24;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned AlphaN  = 256;

  // APB
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Rounding term added before the >> 16 of the un-premultiply step
  localparam logic [ProdW-1:0] RoundTerm = ProdW'(32768);
  localparam logic [ChanW-1:0] ChanMax   = 8'hFF;

  // Reciprocal numerator: 255 * 65536
  localparam int unsigned RecipNum = 255 * 65536;

  typedef enum logic [2:0] {
    RegMode         = 3'd0,
    RegRedShift     = 3'd1,
    RegGreenShift   = 3'd2,
    RegBlueShift    = 3'd3,
    RegAlphaShift   = 3'd4,
    RegAlphaPresent = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ModeRgb565   = 2'd0,
    ModeArgb4444 = 2'd1,
    ModeUnpremul = 2'd2
  } mode_e;

endpackage

// File: design/pixel_pack_with_unpremultiply_top.sv
`timescale 1ns / 1ps

// Pixel packer: takes one 32-bit pixel whose four 8-bit channels sit at the
// programmed bit offsets and returns one 16-bit pixel, RGB565, ARGB4444, or
// ARGB4444 with the colour channels un-premultiplied by alpha through a
// 256-entry reciprocal ROM. One pixel per clock is sustained while out_ready_i
// stays high; each pixel passes through four register stages (channel extract,
// reciprocal ROM, three parallel 8x24 multipliers, saturate and pack). The last
// flag rides along with its pixel. Program the registers over APB only while no
// pixel is in flight; pready is always high.
module pixel_pack_with_unpremultiply_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppu_pkg::AddrW-1:0]       paddr,
  input  logic [ppu_pkg::DataW-1:0]       pwdata,
  output logic [ppu_pkg::DataW-1:0]       prdata,
  output logic                            pready,
  // input stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ppu_pkg::PixInW-1:0]      source_pixel_i,
  input  logic                            last_in_i,
  // output stream
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ppu_pkg::PixOutW-1:0]     packed_pixel_o,
  output logic                            last_out_o
);

  localparam int unsigned CW = ppu_pkg::ChanW;
  localparam int unsigned SW = ppu_pkg::ShiftW;
  localparam int unsigned RW = ppu_pkg::RecipW;
  localparam int unsigned PW = ppu_pkg::ProdW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]    mode_q;
  logic [SW-1:0] red_shift_q, green_shift_q, blue_shift_q, alpha_shift_q;
  logic          alpha_present_q;
  logic          cfg_wr;
  ppu_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ppu_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= ppu_pkg::ModeRgb565;
      red_shift_q     <= SW'(16);
      green_shift_q   <= SW'(8);
      blue_shift_q    <= SW'(0);
      alpha_shift_q   <= SW'(24);
      alpha_present_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ppu_pkg::RegMode:         mode_q          <= pwdata[1:0];
        ppu_pkg::RegRedShift:     red_shift_q     <= pwdata[SW-1:0];
        ppu_pkg::RegGreenShift:   green_shift_q   <= pwdata[SW-1:0];
        ppu_pkg::RegBlueShift:    blue_shift_q    <= pwdata[SW-1:0];
        ppu_pkg::RegAlphaShift:   alpha_shift_q   <= pwdata[SW-1:0];
        ppu_pkg::RegAlphaPresent: alpha_present_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      ppu_pkg::RegMode:         prdata = ppu_pkg::DataW'(mode_q);
      ppu_pkg::RegRedShift:     prdata = ppu_pkg::DataW'(red_shift_q);
      ppu_pkg::RegGreenShift:   prdata = ppu_pkg::DataW'(green_shift_q);
      ppu_pkg::RegBlueShift:    prdata = ppu_pkg::DataW'(blue_shift_q);
      ppu_pkg::RegAlphaShift:   prdata = ppu_pkg::DataW'(alpha_shift_q);
      ppu_pkg::RegAlphaPresent: prdata = ppu_pkg::DataW'(alpha_present_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Reciprocal ROM: round(255 * 65536 / a), 0 for a == 0
  // ---------------------------------------------------------------------------
  logic [RW-1:0] recip_rom [ppu_pkg::AlphaN];

  for (genvar i = 0; i < ppu_pkg::AlphaN; i++) begin : g_rom
    localparam int unsigned Div   = (i == 0) ? 1 : i;
    localparam int unsigned Value = (i == 0) ? 0 : (ppu_pkg::RecipNum + i / 2) / Div;
    assign recip_rom[i] = RW'(Value);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage advances when empty or when the next one moves
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4       = !s4_v_q || out_ready_i;
  assign adv3       = !s3_v_q || adv4;
  assign adv2       = !s2_v_q || adv3;
  assign adv1       = !s1_v_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= in_valid_i;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
      if (adv4) s4_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: channel extract
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s1_r_q, s1_g_q, s1_b_q, s1_a_q;
  logic          s1_last_q;
  logic [ppu_pkg::PixInW-1:0] sh_r, sh_g, sh_b, sh_a;

  // bits above bit 31 read as zero
  assign sh_r = source_pixel_i >> red_shift_q;
  assign sh_g = source_pixel_i >> green_shift_q;
  assign sh_b = source_pixel_i >> blue_shift_q;
  assign sh_a = source_pixel_i >> alpha_shift_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_r_q    <= sh_r[CW-1:0];
      s1_g_q    <= sh_g[CW-1:0];
      s1_b_q    <= sh_b[CW-1:0];
      s1_a_q    <= alpha_present_q ? sh_a[CW-1:0] : ppu_pkg::ChanMax;
      s1_last_q <= last_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: reciprocal lookup
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s2_r_q, s2_g_q, s2_b_q, s2_a_q;
  logic [RW-1:0] s2_recip_q;
  logic          s2_last_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_r_q     <= s1_r_q;
      s2_g_q     <= s1_g_q;
      s2_b_q     <= s1_b_q;
      s2_a_q     <= s1_a_q;
      s2_recip_q <= recip_rom[s1_a_q];
      s2_last_q  <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale each colour by the reciprocal, add rounding term.
  // Alpha 0 gives a zero reciprocal and alpha 255 gives exactly 65536, so both
  // special cases fall out of the arithmetic.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s3_r_q, s3_g_q, s3_b_q, s3_a_q;
  logic [PW-1:0] s3_pr_q, s3_pg_q, s3_pb_q;
  logic          s3_last_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_r_q    <= s2_r_q;
      s3_g_q    <= s2_g_q;
      s3_b_q    <= s2_b_q;
      s3_a_q    <= s2_a_q;
      s3_pr_q   <= PW'(s2_r_q) * PW'(s2_recip_q) + ppu_pkg::RoundTerm;
      s3_pg_q   <= PW'(s2_g_q) * PW'(s2_recip_q) + ppu_pkg::RoundTerm;
      s3_pb_q   <= PW'(s2_b_q) * PW'(s2_recip_q) + ppu_pkg::RoundTerm;
      s3_last_q <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: saturate and pack
  // ---------------------------------------------------------------------------
  logic [CW-1:0] u_r, u_g, u_b, c_r, c_g, c_b;
  logic [ppu_pkg::PixOutW-1:0] pix_d, pix_q;
  logic          last_q;
  logic          unpremul;

  function automatic logic [CW-1:0] sat_chan(input logic [PW-1:0] p);
    logic [PW-17:0] v;
    v = p[PW-1:16];
    return (|v[PW-17:CW]) ? ppu_pkg::ChanMax : v[CW-1:0];
  endfunction

  // mode 3 shares the un-premultiply path
  assign unpremul = mode_q[1];

  assign u_r = sat_chan(s3_pr_q);
  assign u_g = sat_chan(s3_pg_q);
  assign u_b = sat_chan(s3_pb_q);
  assign c_r = unpremul ? u_r : s3_r_q;
  assign c_g = unpremul ? u_g : s3_g_q;
  assign c_b = unpremul ? u_b : s3_b_q;

  always_comb begin
    if (mode_q == ppu_pkg::ModeRgb565) begin
      pix_d = {s3_r_q[7:3], s3_g_q[7:2], s3_b_q[7:3]};
    end else begin
      pix_d = {s3_a_q[7:4], c_r[7:4], c_g[7:4], c_b[7:4]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      pix_q  <= pix_d;
      last_q <= s3_last_q;
    end
  end

  assign out_valid_o    = s4_v_q;
  assign packed_pixel_o = pix_q;
  assign last_out_o     = last_q;

`ifndef SYNTHESIS
  // zero alpha leaves only the rounding term in every product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && (s3_a_q == '0) |->
      (s3_pr_q == ppu_pkg::RoundTerm) && (s3_pg_q == ppu_pkg::RoundTerm) &&
      (s3_pb_q == ppu_pkg::RoundTerm))
    else $error("zero alpha did not clear colour products");

  // full alpha must pass colour through the multiplier unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && (s3_a_q == ppu_pkg::ChanMax) |->
      (s3_pr_q[PW-1:16] == 16'(s3_r_q)) && (s3_pg_q[PW-1:16] == 16'(s3_g_q)) &&
      (s3_pb_q[PW-1:16] == 16'(s3_b_q)))
    else $error("full alpha altered colour");

  // the input side stalls only when the whole pipe is backed up by the sink
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && s1_v_q && s2_v_q && s3_v_q)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
